// ----- rtl/sdrrx_pkg.sv -----
package sdrrx_pkg;

	// Frame geometry
	localparam int NUM_RECEIVERS = 2;
	localparam int FRAME_BYTES   = 512;
	localparam int SYNC_BYTES    = 3;
	localparam int HDR_BYTES     = 8;
	localparam int SAMPLE_BYTES  = 6;
	localparam int IQ_LEN        = NUM_RECEIVERS * SAMPLE_BYTES;
	localparam int GROUP_BYTES   = IQ_LEN + 2;
	localparam int GROUP_COUNT   = (FRAME_BYTES - HDR_BYTES) / GROUP_BYTES;
	localparam int DATA_END      = HDR_BYTES + GROUP_COUNT * GROUP_BYTES;

	localparam int POS_W  = $clog2(FRAME_BYTES + 1);
	localparam int GOFF_W = $clog2(GROUP_BYTES);
	localparam int SOFF_W = $clog2(SAMPLE_BYTES);
	localparam int RX_W   = 3;

	localparam logic [7:0] SYNC_BYTE = 8'h7F;

	// Queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int QDATA_W = 48;

	// Result kinds, also the op codes carried through the queue
	localparam logic [1:0] KIND_IQ   = 2'd0;
	localparam logic [1:0] KIND_MIC  = 2'd1;
	localparam logic [1:0] KIND_CTRL = 2'd2;
	localparam logic [1:0] KIND_SYNC = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIC_DIVISOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MIC   = 2'd1;
	localparam int CFG_DATA_W = 8;

	typedef struct packed {
		logic [1:0]         kind;
		logic [RX_W-1:0]    rx;
		logic [QDATA_W-1:0] data;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	typedef struct packed {
		logic [3:0] mic_divisor;
		logic       local_mic;
	} cfg_t;

endpackage

// ----- rtl/sdrrx_queue.sv -----
module sdrrx_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sdrrx_pkg::q_entry_t wr_entry,
	input  logic                pop,
	output sdrrx_pkg::q_entry_t rd_entry,
	output sdrrx_pkg::q_status_t status
);

	sdrrx_pkg::q_entry_t             mem_q [sdrrx_pkg::QDEPTH];
	logic [sdrrx_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sdrrx_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sdrrx_pkg::QCNT_W-1:0]    count_q;

	assign status.full      = (count_q == sdrrx_pkg::QCNT_W'(sdrrx_pkg::QDEPTH));
	assign status.not_empty = (count_q != '0);
	assign rd_entry         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/sdrrx_front.sv -----
module sdrrx_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	output logic                push,
	output sdrrx_pkg::q_entry_t entry
);

	localparam logic [sdrrx_pkg::POS_W-1:0] FRAME_END_P =
		sdrrx_pkg::POS_W'(sdrrx_pkg::FRAME_BYTES);
	localparam logic [sdrrx_pkg::POS_W-1:0] SYNC_END_P =
		sdrrx_pkg::POS_W'(sdrrx_pkg::SYNC_BYTES);
	localparam logic [sdrrx_pkg::POS_W-1:0] CTRL_LAST_P =
		sdrrx_pkg::POS_W'(sdrrx_pkg::HDR_BYTES - 1);
	localparam logic [sdrrx_pkg::POS_W-1:0] DATA_END_P =
		sdrrx_pkg::POS_W'(sdrrx_pkg::DATA_END);
	localparam logic [sdrrx_pkg::GOFF_W-1:0] IQ_LEN_P =
		sdrrx_pkg::GOFF_W'(sdrrx_pkg::IQ_LEN);
	localparam logic [sdrrx_pkg::GOFF_W-1:0] MIC_LO_P =
		sdrrx_pkg::GOFF_W'(sdrrx_pkg::IQ_LEN + 1);
	localparam logic [sdrrx_pkg::GOFF_W-1:0] GROUP_LAST_P =
		sdrrx_pkg::GOFF_W'(sdrrx_pkg::GROUP_BYTES - 1);
	localparam logic [sdrrx_pkg::SOFF_W-1:0] SAMPLE_LAST_P =
		sdrrx_pkg::SOFF_W'(sdrrx_pkg::SAMPLE_BYTES - 1);

	logic [sdrrx_pkg::POS_W-1:0]  pos_q, pos_d, p_eff;
	logic                         fvalid_q, fvalid_d;
	logic [sdrrx_pkg::GOFF_W-1:0] goff_q, goff_d;
	logic [sdrrx_pkg::SOFF_W-1:0] soff_q, soff_d;
	logic [sdrrx_pkg::RX_W-1:0]   rx_q, rx_d;
	logic [7:0]                   ctl_q [4];
	logic [39:0]                  shift_q;
	logic                         accept, live, ctl_we, shift_we;
	logic [1:0]                   ctl_idx;

	assign accept  = in_valid && !in_stall;
	assign p_eff   = frame_start ? '0 : pos_q;
	assign live    = (frame_start || fvalid_q) && (p_eff < FRAME_END_P);
	assign ctl_idx = 2'(p_eff - SYNC_END_P);

	always_comb begin
		pos_d      = pos_q;
		fvalid_d   = fvalid_q;
		goff_d     = goff_q;
		soff_d     = soff_q;
		rx_d       = rx_q;
		ctl_we     = 1'b0;
		shift_we   = 1'b0;
		push       = 1'b0;
		entry.kind = sdrrx_pkg::KIND_IQ;
		entry.rx   = rx_q;
		entry.data = {shift_q, rx_byte};
		if (accept && live) begin
			pos_d    = p_eff + 1'b1;
			fvalid_d = 1'b1;
			if (p_eff < SYNC_END_P) begin
				if (rx_byte != sdrrx_pkg::SYNC_BYTE) begin
					push       = 1'b1;
					entry.kind = sdrrx_pkg::KIND_SYNC;
					fvalid_d   = 1'b0;
				end
			end else if (p_eff < CTRL_LAST_P) begin
				ctl_we = 1'b1;
			end else if (p_eff == CTRL_LAST_P) begin
				// Hand all five control bytes to the back end
				push       = 1'b1;
				entry.kind = sdrrx_pkg::KIND_CTRL;
				entry.data = {8'h00, ctl_q[0], ctl_q[1], ctl_q[2], ctl_q[3], rx_byte};
				goff_d     = '0;
				soff_d     = '0;
				rx_d       = '0;
			end else if (p_eff < DATA_END_P) begin
				shift_we = 1'b1;
				if (goff_q < IQ_LEN_P) begin
					if (soff_q == SAMPLE_LAST_P) begin
						push   = 1'b1;
						soff_d = '0;
						rx_d   = rx_q + 1'b1;
					end else begin
						soff_d = soff_q + 1'b1;
					end
				end else if (goff_q == MIC_LO_P) begin
					push       = 1'b1;
					entry.kind = sdrrx_pkg::KIND_MIC;
					entry.data = {32'h0, shift_q[7:0], rx_byte};
				end
				if (goff_q == GROUP_LAST_P) begin
					goff_d = '0;
					soff_d = '0;
					rx_d   = '0;
				end else begin
					goff_d = goff_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= FRAME_END_P;
			fvalid_q <= 1'b0;
			goff_q   <= '0;
			soff_q   <= '0;
			rx_q     <= '0;
		end else begin
			pos_q    <= pos_d;
			fvalid_q <= fvalid_d;
			goff_q   <= goff_d;
			soff_q   <= soff_d;
			rx_q     <= rx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_we) begin
			ctl_q[ctl_idx] <= rx_byte;
		end
		if (shift_we) begin
			shift_q <= {shift_q[31:0], rx_byte};
		end
	end

endmodule

// ----- rtl/sdrrx_back.sv -----
module sdrrx_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdrrx_pkg::cfg_t      cfg,
	input  sdrrx_pkg::q_entry_t  rd_entry,
	input  sdrrx_pkg::q_status_t q_status,
	output logic                 pop,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [1:0]           result_kind,
	output logic [2:0]           receiver_index,
	output logic signed [23:0]   i_sample,
	output logic signed [23:0]   q_sample,
	output logic signed [15:0]   mic_word,
	output logic [2:0]           key_bits,
	output logic                 key_changed,
	output logic [4:0]           status_address,
	output logic [15:0]          status_word_a,
	output logic [15:0]          status_word_b,
	output logic                 overload_flag,
	output logic [2:0]           io_inputs
);

	logic        valid_q;
	logic [2:0]  prev_keys_q, prev_keys_d;
	logic [3:0]  mic_cnt_q, mic_cnt_d, mic_cnt_inc;
	logic        can_load, emit;
	logic [7:0]  c0, c1;

	logic [1:0]  kind_d;
	logic [2:0]  rx_d, keys_d, io_d;
	logic [23:0] i_d, q_d;
	logic [15:0] mic_d, wa_d, wb_d;
	logic        chg_d, adc_d;
	logic [4:0]  addr_d;

	assign can_load    = !valid_q || !out_stall;
	assign pop         = q_status.not_empty && can_load;
	assign c0          = rd_entry.data[39:32];
	assign c1          = rd_entry.data[31:24];
	assign mic_cnt_inc = mic_cnt_q + 1'b1;
	assign out_valid   = valid_q;

	always_comb begin
		emit        = 1'b1;
		prev_keys_d = prev_keys_q;
		mic_cnt_d   = mic_cnt_q;
		kind_d      = rd_entry.kind;
		rx_d        = '0;
		i_d         = '0;
		q_d         = '0;
		mic_d       = '0;
		keys_d      = '0;
		chg_d       = 1'b0;
		addr_d      = '0;
		wa_d        = '0;
		wb_d        = '0;
		adc_d       = 1'b0;
		io_d        = '0;
		unique case (rd_entry.kind)
			sdrrx_pkg::KIND_IQ: begin
				rx_d = rd_entry.rx;
				i_d  = rd_entry.data[47:24];
				q_d  = rd_entry.data[23:0];
			end
			sdrrx_pkg::KIND_MIC: begin
				// Hold the decimation count while the local microphone is in use
				if (cfg.local_mic) begin
					emit = 1'b0;
				end else if (mic_cnt_inc >= cfg.mic_divisor) begin
					mic_d     = rd_entry.data[15:0];
					mic_cnt_d = '0;
				end else begin
					emit      = 1'b0;
					mic_cnt_d = mic_cnt_inc;
				end
			end
			sdrrx_pkg::KIND_CTRL: begin
				keys_d      = c0[2:0];
				chg_d       = (c0[2:0] != prev_keys_q);
				addr_d      = c0[7:3];
				wa_d        = rd_entry.data[31:16];
				wb_d        = rd_entry.data[15:0];
				prev_keys_d = c0[2:0];
				if (c0[7:3] == 5'd0) begin
					adc_d = c1[0];
					io_d  = ~c1[3:1];
				end
			end
			sdrrx_pkg::KIND_SYNC: begin
				kind_d = sdrrx_pkg::KIND_SYNC;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			prev_keys_q <= '0;
			mic_cnt_q   <= '0;
		end else begin
			if (can_load) begin
				valid_q <= pop && emit;
			end
			if (pop) begin
				prev_keys_q <= prev_keys_d;
				mic_cnt_q   <= mic_cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			result_kind    <= kind_d;
			receiver_index <= rx_d;
			i_sample       <= i_d;
			q_sample       <= q_d;
			mic_word       <= mic_d;
			key_bits       <= keys_d;
			key_changed    <= chg_d;
			status_address <= addr_d;
			status_word_a  <= wa_d;
			status_word_b  <= wb_d;
			overload_flag  <= adc_d;
			io_inputs      <= io_d;
		end
	end

endmodule

// ----- rtl/sdr_rx_frame_deframer.sv -----
// Receive-frame deframer: one byte of a 512-byte link frame per input transaction.
// Input channel: rx_byte and frame_start under in_valid / in_stall; frame_start
// marks byte 0 and restarts parsing even in mid-frame. Output channel: one result
// transaction under out_valid / out_stall, result_kind telling IQ pair, microphone
// sample, control info or sync error; fields not belonging to the kind read 0.
// Configuration: cfg_valid / cfg_ready (always ready) with cfg_index and cfg_data;
// index 0 is the microphone divisor, index 1 the local microphone select. Write
// only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. The front end classifies
// each byte in the cycle it is accepted and pushes an op into a four-entry queue;
// the back end takes one op per cycle unless the output stalls, turning it into a
// registered result or dropping it, as for decimated microphone ops. A result
// travels from its last byte through the queue entry into the output register.
// Stall: a held out_stall freezes the output register; the queue absorbs up to
// four further ops, after which in_stall rises until the output drains.
// Reset: the parser goes idle and ignores bytes until the next frame_start; the
// key history, decimation count and queue clear, divisor returns to 1.
module sdr_rx_frame_deframer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rx_byte,
	input  logic                                 frame_start,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sdrrx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sdrrx_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           result_kind,
	output logic [2:0]                           receiver_index,
	output logic signed [23:0]                   i_sample,
	output logic signed [23:0]                   q_sample,
	output logic signed [15:0]                   mic_word,
	output logic [2:0]                           key_bits,
	output logic                                 key_changed,
	output logic [4:0]                           status_address,
	output logic [15:0]                          status_word_a,
	output logic [15:0]                          status_word_b,
	output logic                                 overload_flag,
	output logic [2:0]                           io_inputs
);

	sdrrx_pkg::cfg_t      cfg_q;
	sdrrx_pkg::q_entry_t  wr_entry, rd_entry;
	sdrrx_pkg::q_status_t q_status;
	logic                 push, pop;

	// The register file never backpressures
	assign cfg_ready = 1'b1;
	// Hold input bytes while the queue is full
	assign in_stall  = q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mic_divisor <= 4'd1;
			cfg_q.local_mic   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sdrrx_pkg::CFG_MIC_DIVISOR) begin
				cfg_q.mic_divisor <= cfg_data[3:0];
			end else if (cfg_index == sdrrx_pkg::CFG_LOCAL_MIC) begin
				cfg_q.local_mic <= cfg_data[0];
			end
		end
	end

	sdrrx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.push        (push),
		.entry       (wr_entry)
	);

	sdrrx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.status   (q_status)
	);

	sdrrx_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.rd_entry       (rd_entry),
		.q_status       (q_status),
		.pop            (pop),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.result_kind    (result_kind),
		.receiver_index (receiver_index),
		.i_sample       (i_sample),
		.q_sample       (q_sample),
		.mic_word       (mic_word),
		.key_bits       (key_bits),
		.key_changed    (key_changed),
		.status_address (status_address),
		.status_word_a  (status_word_a),
		.status_word_b  (status_word_b),
		.overload_flag  (overload_flag),
		.io_inputs      (io_inputs)
	);

endmodule

// ----- dv/deframe_checker.sv -----
`timescale 1ns / 100ps

module deframe_checker
	import sdrrx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [7:0]            rx_byte,
	input  logic                  frame_start,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [1:0]            result_kind,
	input  logic [2:0]            receiver_index,
	input  logic [23:0]           i_sample,
	input  logic [23:0]           q_sample,
	input  logic [15:0]           mic_word,
	input  logic [2:0]            key_bits,
	input  logic                  key_changed,
	input  logic [4:0]            status_address,
	input  logic [15:0]           status_word_a,
	input  logic [15:0]           status_word_b,
	input  logic                  overload_flag,
	input  logic [2:0]            io_inputs,
	output int                    mismatch_count,
	output int                    results_owed
);

	localparam int FRAME_LEN  = 512;
	localparam int RECEIVERS  = 2;
	localparam int SYNC_LEN   = 3;
	localparam int HEADER_LEN = 8;
	localparam int PAIR_BYTES = 6;
	localparam int IQ_BYTES   = RECEIVERS * PAIR_BYTES;
	localparam int GROUP_LEN  = IQ_BYTES + 2;
	localparam int DATA_LIMIT = HEADER_LEN + ((FRAME_LEN - HEADER_LEN) / GROUP_LEN) * GROUP_LEN;
	localparam logic [7:0] SYNC_PATTERN = 8'h7F;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  rx;
		logic [23:0] i_s;
		logic [23:0] q_s;
		logic [15:0] mic;
		logic [2:0]  keys;
		logic        keys_moved;
		logic [4:0]  addr;
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic        ovl;
		logic [2:0]  io;
	} deframe_result_t;

	deframe_result_t owed_results [$];

	int unsigned frame_pos   = FRAME_LEN;
	bit          in_frame    = 1'b0;
	logic [7:0]  ctl_bytes [4];
	logic [39:0] tail_bytes  = '0;
	logic [2:0]  rx_count    = '0;
	logic [2:0]  last_keys   = '0;
	logic [3:0]  mic_count   = '0;
	logic [3:0]  divisor_reg = 4'd1;
	logic        local_reg   = 1'b0;
	int          mismatches  = 0;

	initial begin
		mismatch_count = 0;
		results_owed   = 0;
	end

	// Advance the parser by one byte; return 1 when the byte completes a result.
	function automatic bit parse_frame_byte(input logic [7:0] b, input logic first,
			output deframe_result_t r);
		int unsigned p;
		int unsigned off;
		bit emitted;
		r = '0;
		emitted = 1'b0;
		if (first) begin
			frame_pos = 0;
			in_frame = 1'b1;
		end
		if (!in_frame || frame_pos >= FRAME_LEN)
			return 1'b0;
		p = frame_pos;
		if (p < SYNC_LEN) begin
			if (b != SYNC_PATTERN) begin
				r.kind = KIND_SYNC;
				in_frame = 1'b0;
				emitted = 1'b1;
			end
		end else if (p < HEADER_LEN - 1) begin
			ctl_bytes[p - SYNC_LEN] = b;
		end else if (p == HEADER_LEN - 1) begin
			r.kind = KIND_CTRL;
			r.keys = ctl_bytes[0][2:0];
			r.keys_moved = (ctl_bytes[0][2:0] != last_keys);
			r.addr = ctl_bytes[0][7:3];
			r.word_a = {ctl_bytes[1], ctl_bytes[2]};
			r.word_b = {ctl_bytes[3], b};
			if (r.addr == 5'd0) begin
				r.ovl = ctl_bytes[1][0];
				r.io = ~ctl_bytes[1][3:1];
			end
			last_keys = ctl_bytes[0][2:0];
			rx_count = '0;
			emitted = 1'b1;
		end else if (p < DATA_LIMIT) begin
			off = (p - HEADER_LEN) % GROUP_LEN;
			if (off == 0)
				rx_count = '0;
			if (off < IQ_BYTES) begin
				if (off % PAIR_BYTES == PAIR_BYTES - 1) begin
					r.kind = KIND_IQ;
					r.rx = rx_count;
					r.i_s = tail_bytes[39:16];
					r.q_s = {tail_bytes[15:0], b};
					rx_count = rx_count + 3'd1;
					emitted = 1'b1;
				end
			end else if (off == IQ_BYTES + 1 && !local_reg) begin
				mic_count = mic_count + 4'd1;
				if (mic_count >= divisor_reg) begin
					r.kind = KIND_MIC;
					r.mic = {tail_bytes[7:0], b};
					mic_count = '0;
					emitted = 1'b1;
				end
			end
			tail_bytes = {tail_bytes[31:0], b};
		end
		frame_pos = p + 1;
		return emitted;
	endfunction

	task automatic check_field(input string field, input logic signed [31:0] want_v,
			input logic signed [31:0] seen_v);
		if (seen_v !== want_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, seen_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		deframe_result_t want;
		deframe_result_t seen;
		if (!arst_n) begin
			owed_results.delete();
			frame_pos = FRAME_LEN;
			in_frame = 1'b0;
			rx_count = '0;
			last_keys = '0;
			mic_count = '0;
			divisor_reg = 4'd1;
			local_reg = 1'b0;
			results_owed <= 0;
		end else begin
			// Outputs first: a result can never stem from a byte taken at this edge.
			if (out_valid && !out_stall) begin
				seen = '{result_kind, receiver_index, i_sample, q_sample, mic_word,
					key_bits, key_changed, status_address, status_word_a, status_word_b,
					overload_flag, io_inputs};
				if (owed_results.size() == 0) begin
					$error("result of kind %0d with nothing expected", result_kind);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					check_field("result_kind", want.kind, seen.kind);
					check_field("receiver_index", want.rx, seen.rx);
					check_field("i_sample", $signed(want.i_s), $signed(seen.i_s));
					check_field("q_sample", $signed(want.q_s), $signed(seen.q_s));
					check_field("mic_word", $signed(want.mic), $signed(seen.mic));
					check_field("key_bits", want.keys, seen.keys);
					check_field("key_changed", want.keys_moved, seen.keys_moved);
					check_field("status_address", want.addr, seen.addr);
					check_field("status_word_a", want.word_a, seen.word_a);
					check_field("status_word_b", want.word_b, seen.word_b);
					check_field("overload_flag", want.ovl, seen.ovl);
					check_field("io_inputs", want.io, seen.io);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIC_DIVISOR: divisor_reg = cfg_data[3:0];
					CFG_LOCAL_MIC:   local_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (parse_frame_byte(rx_byte, frame_start, want))
					owed_results.push_back(want);
			end
			results_owed <= owed_results.size();
		end
		mismatch_count <= mismatches;
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import sdrrx_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;	// long output hold-off, enough to back up the input
	localparam int QUIET_CYCLES  = 8;	// settle time after the last result, covers the pipeline
	localparam int FRAME_LEN     = 512;
	localparam int SEGMENTS      = 8;
	localparam int SEGMENT_ITEMS = 200;
	localparam logic [7:0] SYNC_PATTERN = 8'h7F;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;	// no register behind it

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Block inputs, all known from time zero
	logic                  in_valid = 1'b0;
	logic [7:0]            rx_byte = 8'h00;
	logic                  frame_start = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  out_stall = 1'b0;

	// Block outputs
	logic                  in_stall;
	logic                  cfg_ready;
	logic                  out_valid;
	logic [1:0]            result_kind;
	logic [2:0]            receiver_index;
	logic signed [23:0]    i_sample;
	logic signed [23:0]    q_sample;
	logic signed [15:0]    mic_word;
	logic [2:0]            key_bits;
	logic                  key_changed;
	logic [4:0]            status_address;
	logic [15:0]           status_word_a;
	logic [15:0]           status_word_b;
	logic                  overload_flag;
	logic [2:0]            io_inputs;

	int mismatch_count;
	int results_owed;

	// Traffic shaping: percentages of cycles in which each side idles
	int send_idle_pct = 19;
	int recv_idle_pct = 58;
	int holds_asked = 0;
	int holds_taken = 0;
	int hold_left = 0;

	int unsigned parsed_items = 0;	// random-phase bytes the parser actually consumes
	bit frame_open = 1'b0;		// a frame was cut short and still runs in the block
	int unsigned cycle_count = 0;

	// One setting per random segment; the divisor drops from high to low so that
	// a held count beyond the new divisor gets exercised, and zero and 15 are hit.
	logic [3:0] seg_divisor [SEGMENTS] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd1, 4'd7, 4'd5};
	logic       seg_local   [SEGMENTS] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

	// Directed frame head: sync, control with address 0 and all keys set, then an IQ
	// pair at the sample extremes, a pair of -1 and 0, and the most negative mic sample.
	logic [7:0] head_pattern [22] = '{
		8'h7F, 8'h7F, 8'h7F,
		8'h07, 8'hF1, 8'h00, 8'hFF, 8'h00,
		8'h7F, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00,
		8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
		8'h80, 8'h00
	};

	sdr_rx_frame_deframer u_top (.*);

	deframe_checker u_checker (.*);

	always #6 clk = ~clk;

	// Abort a run that has hung somewhere
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver side: random back-pressure, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (holds_taken != holds_asked) begin
			holds_taken = holds_taken + 1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Offer one byte, idling first at random, and hold it until the block takes it
	task automatic send_byte(input logic [7:0] b, input logic first, input bit counted);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= first;
		do
			@(posedge clk);
		while (in_stall);
		if (counted)
			parsed_items++;
	endtask

	// Drop valid and wait for every owed result, then let the pipeline settle
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// Upper data bits carry noise; only the register's own bits should matter
	task automatic apply_settings(input logic [3:0] divisor, input logic local_mic_sel,
			input bit poke_spare);
		write_reg(CFG_MIC_DIVISOR, {4'($urandom), divisor});
		write_reg(CFG_LOCAL_MIC, {7'($urandom), local_mic_sel});
		if (poke_spare)
			write_reg(CFG_IDX_SPARE, 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Well-formed frame of len bytes with random content; a short one is left
	// open and gets abandoned by the next frame start.
	task automatic send_good_frame(input int len);
		logic [7:0] b;
		for (int pos = 0; pos < len; pos++) begin
			if (pos < 3)
				b = SYNC_PATTERN;
			else if (pos == 3)
				b = {($urandom_range(1) != 0) ? 5'd0 : 5'($urandom), 3'($urandom)};
			else begin
				case ($urandom_range(7))
					0: b = 8'h00;
					1: b = 8'hFF;
					2: b = 8'h7F;
					3: b = 8'h80;
					default: b = 8'($urandom);
				endcase
			end
			send_byte(b, pos == 0, 1'b1);
		end
		frame_open = (len < FRAME_LEN);
	endtask

	// Break the sync at a random position, then trail bytes the block must ignore
	task automatic send_bad_sync();
		int good_lead;
		logic [7:0] b;
		good_lead = $urandom_range(2);
		for (int pos = 0; pos < good_lead; pos++)
			send_byte(SYNC_PATTERN, pos == 0, 1'b1);
		b = 8'($urandom_range(254));
		if (b >= SYNC_PATTERN)
			b++;
		send_byte(b, good_lead == 0, 1'b1);
		repeat ($urandom_range(6)) send_byte(8'($urandom), 1'b0, 1'b0);
		frame_open = 1'b0;
	endtask

	task automatic run_segment(input int unsigned target);
		int unsigned stop_at;
		int unsigned halfway;
		int unsigned len;
		int pick;
		bit paused;
		stop_at = parsed_items + target;
		halfway = parsed_items + target / 2;
		paused = 1'b0;
		while (parsed_items < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70 || (pick >= 88 && frame_open)) begin
				len = ($urandom_range(3) == 0) ? FRAME_LEN : $urandom_range(1, 120);
				// trim the last frame so the segment lands close to its target
				if (len > stop_at - parsed_items)
					len = stop_at - parsed_items;
				send_good_frame(int'(len));
			end else if (pick < 88)
				send_bad_sync();
			else begin
				// stray bytes while no frame runs, all with a clear start flag
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0, 1'b0);
			end
			// hold the sender once per segment until the block has caught up
			if (!paused && parsed_items >= halfway) begin
				paused = 1'b1;
				wait_results_drained();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset settings written explicitly
		apply_settings(4'd1, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);		// idle: no frame yet, drop it
		send_byte(SYNC_PATTERN, 1'b1, 1'b0);	// abandoned by the restart below
		for (int k = 0; k < 22; k++)
			send_byte(head_pattern[k], k == 0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);		// sync mismatch on the very first byte
		wait_results_drained();

		// Random part: sender-light, then receiver-light, then no idling at all
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 3) begin
				send_idle_pct = 58;
				recv_idle_pct <= 19;
			end else if (seg == 6) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			apply_settings(seg_divisor[seg], seg_local[seg], seg == 2);
			if (seg == 0 || seg == 3)
				holds_asked <= holds_asked + 1;
			run_segment(SEGMENT_ITEMS);
			wait_results_drained();
		end

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sdrrx_pkg.sv
rtl/sdrrx_queue.sv
rtl/sdrrx_front.sv
rtl/sdrrx_back.sv
rtl/sdr_rx_frame_deframer.sv
dv/deframe_checker.sv
dv/testbench.sv
